// ===== src/sobel_edge_magnitude_macros.svh =====
// ============================================================================
// Sobel edge magnitude assertion macros
// Concurrent check macros for the top-level RTL file; empty under synthesis.
// ============================================================================
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SOBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel_edge_magnitude: check failed");
// Next-cycle implication check.
`define SOBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel_edge_magnitude: check failed");
`else
`define SOBM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SOBM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/sobm_pkg.sv =====
// ============================================================================
// Sobel edge magnitude package
// Shared types, register indexes and field widths.
// ============================================================================
`default_nettype none
package sobm_pkg;
  // Field widths.
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int GRAD_W = 11;
  localparam int SUM_W  = 21;
  localparam int ROW_W  = 17;
  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // Item sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_GRAD   = 5'b00100,
    S_SQUARE = 5'b01000,
    S_ROOT   = 5'b10000
  } state_t;

  // Border flags of the output pixel, plus the end-of-frame mark.
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic last;
  } edge_mask_t;
endpackage
`default_nettype wire

// ===== src/sobm_line_store.sv =====
// ============================================================================
// Sobel line store
// Two row buffers sharing one address, registered read, one write per cycle.
// ============================================================================
`default_nettype none
module sobm_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic [sobm_pkg::PIX_W-1:0]   rd_upper,
  output logic [sobm_pkg::PIX_W-1:0]   rd_middle,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [sobm_pkg::PIX_W-1:0] wr_upper,
  input  wire logic [sobm_pkg::PIX_W-1:0] wr_middle
);
  import sobm_pkg::*;

  logic [PIX_W-1:0] upper_mem  [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  // Registered read of both rows.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

  // Write back the shifted column.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end
endmodule
`default_nettype wire

// ===== src/sobm_root.sv =====
// ============================================================================
// Sobel rounded root
// Finds the largest n below 256 with n*(n-1) < sum, one bit per cycle.
// ============================================================================
`default_nettype none
module sobm_root (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sobm_pkg::SUM_W-1:0] sum_sq,
  output logic                           done,
  output logic [sobm_pkg::CH_W-1:0]      root
);
  import sobm_pkg::*;

  localparam int BIT_W = $clog2(CH_W);

  logic [SUM_W-1:0]   sum_r;
  logic [CH_W-1:0]    n_r;
  logic [BIT_W-1:0]   bit_r;
  logic               busy_r;
  logic               done_r;
  logic [CH_W-1:0]    cand;
  logic [2*CH_W-1:0]  prod;

  // Trial value with the current bit set.
  always_comb begin
    cand = n_r | (CH_W'(1) << bit_r);
    prod = {{CH_W{1'b0}}, cand} * {{CH_W{1'b0}}, cand - CH_W'(1)};
  end

  // Control of the bit loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      bit_r  <= BIT_W'(CH_W - 1);
    end else if (busy_r) begin
      if (bit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        bit_r <= bit_r - BIT_W'(1);
      end
    end
  end

  // Partial root and operand.
  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum_sq;
      n_r   <= '0;
    end else if (busy_r && (SUM_W'(prod) < sum_r)) begin
      n_r <= cand;
    end
  end

  assign done = done_r;
  assign root = n_r;
endmodule
`default_nettype wire

// ===== src/sobel_edge_magnitude.sv =====
// ============================================================================
// Sobel edge magnitude
// Per-channel 3x3 Sobel gradient magnitude over an RGB raster stream.
// ============================================================================
// Usage: pixels enter on the in_ channel in raster order with in_tuser low;
// after the last pixel of a frame, items with in_tuser high flush out the
// remaining results. Each result on the out_ channel belongs to the pixel one
// row plus one pixel earlier; out_tlast marks the frame's final result.
// frame_width and frame_height are written on the cfg_ channel while idle.
// Sequence: a pixel that yields a result passes from acceptance through one
// line store read, gradient and square stages, and an eight-step root loop
// before the next acceptance. Items that yield no result take only the read
// state, and ignored flush items are taken in idle. The result stays in an
// output register, so the next item is taken while the receiver stalls; only
// a second finished result waits. Reset clears positions and registers, then
// a clearing pass writes zeros to all MAX_LINE_PIXELS (1024 by default) row
// buffer entries, one entry per cycle; in_tready stays low until it ends.
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"
module sobel_edge_magnitude #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,  // in_red, in_green, in_blue
  input  wire logic [0:0]                      in_tuser,  // command
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata, // out_red, out_green, out_blue
  output logic                                 out_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sobm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sobm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sobm_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int CW    = $clog2(MAX_LINE_PIXELS + 1);

  state_t state_r, state_nxt;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic [CW-1:0]    wc;
  logic [ROW_W-1:0] hc;
  logic             accept, pixels_due, ignore, emit, wrap, last;
  logic [COL_W-1:0] col0, oc0;
  logic [ROW_W-1:0] row0, or0;
  logic [CW-1:0]    nx, onx;
  edge_mask_t       mask;

  logic [PIX_W-1:0] px_r;
  logic [COL_W-1:0] x_r;
  logic             emit_r;
  edge_mask_t       mask_r;
  logic [PIX_W-1:0] win_r [3][3];

  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  logic [PIX_W-1:0] rd_upper, rd_middle;

  logic signed [GRAD_W-1:0] gx [3], gy [3];
  logic signed [GRAD_W-1:0] gx_r [3], gy_r [3];
  logic [SUM_W-1:0]         sum_sq [3];
  logic [2:0]               root_done;
  logic [CH_W-1:0]          root [3];

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_last_r;
  logic        load_out;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(640);
      frame_height_r <= FH_W'(480);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size.
  always_comb begin
    if (frame_width_r == '0) begin
      wc = CW'(1);
    end else if (32'(frame_width_r) > MAX_LINE_PIXELS) begin
      wc = CW'(MAX_LINE_PIXELS);
    end else begin
      wc = CW'(frame_width_r);
    end
    hc = (frame_height_r == '0) ? ROW_W'(1) : ROW_W'(frame_height_r);
  end

  // Input and output positions for the item on offer.
  always_comb begin
    accept     = in_tvalid && in_tready;
    pixels_due = in_row_r < hc;
    ignore     = in_tuser[0] && pixels_due;
    wrap       = CW'(in_col_r) >= wc;
    col0       = wrap ? '0 : in_col_r;
    row0       = wrap ? in_row_r + ROW_W'(1) : in_row_r;
    nx         = CW'(col0) + CW'(1);
    emit       = !((row0 == '0) || ((row0 == ROW_W'(1)) && (col0 == '0)));
    oc0        = (CW'(out_col_r) >= wc) ? '0 : out_col_r;
    or0        = (CW'(out_col_r) >= wc) ? out_row_r + ROW_W'(1) : out_row_r;
    onx        = CW'(oc0) + CW'(1);
    last       = ((or0 + ROW_W'(1)) >= hc) && (onx >= wc);
    mask.top   = or0 != '0;
    mask.bot   = (or0 + ROW_W'(1)) < hc;
    mask.lft   = oc0 != '0;
    mask.rgt   = onx < wc;
    mask.last  = last;

    in_col_nxt  = (nx >= wc) ? '0 : COL_W'(nx);
    in_row_nxt  = (nx >= wc) ? row0 + ROW_W'(1) : row0;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        out_col_nxt = (onx >= wc) ? '0 : COL_W'(onx);
        out_row_nxt = (onx >= wc) ? or0 + ROW_W'(1) : or0;
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept && !ignore) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Item registers captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      px_r   <= pixels_due ? in_tdata : '0;
      x_r    <= col0;
      emit_r <= emit;
      mask_r <= mask;
    end
  end

  // Clearing pass over the row buffers after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == COL_W'(MAX_LINE_PIXELS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + COL_W'(1);
    end
  end

  // Row buffers: read at acceptance, write back in the next cycle.
  sobm_line_store #(
    .DEPTH (MAX_LINE_PIXELS),
    .AW    (COL_W)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (accept && !ignore),
    .rd_addr   (col0),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (clr_busy_r || (state_r == S_READ)),
    .wr_addr   (clr_busy_r ? clr_addr_r : x_r),
    .wr_upper  (clr_busy_r ? '0 : rd_middle),
    .wr_middle (clr_busy_r ? '0 : px_r)
  );

  // Window shift with the new column from the row buffers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == S_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_upper;
      win_r[1][2] <= rd_middle;
      win_r[2][2] <= px_r;
    end
  end

  // Masked Sobel sums per channel.
  always_comb begin
    logic signed [GRAD_W-1:0] v [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && !mask_r.top) || (r == 2 && !mask_r.bot) ||
              (c == 0 && !mask_r.lft) || (c == 2 && !mask_r.rgt)) begin
            v[r][c] = '0;
          end else begin
            v[r][c] = $signed({3'b000, win_r[r][c][ch*CH_W +: CH_W]});
          end
        end
      end
      gx[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
      gy[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GRAD) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_r[ch] <= gx[ch];
        gy_r[ch] <= gy[ch];
      end
    end
  end

  // Squared magnitude and root per channel.
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic signed [2*GRAD_W-1:0] sqx, sqy, sqs;
    always_comb begin
      sqx = gx_r[ch] * gx_r[ch];
      sqy = gy_r[ch] * gy_r[ch];
      sqs = sqx + sqy;
      sum_sq[ch] = sqs[SUM_W-1:0];
    end
    sobm_root u_root (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (state_r == S_SQUARE),
      .sum_sq (sum_sq[ch]),
      .done   (root_done[ch]),
      .root   (root[ch])
    );
  end

  // Item sequencer.
  assign in_tready = (state_r == S_IDLE) && !clr_busy_r;
  assign load_out  = (state_r == S_ROOT) && root_done[0] && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && !ignore) state_nxt = S_READ;
      S_READ:   state_nxt = emit_r ? S_GRAD : S_IDLE;
      S_GRAD:   state_nxt = S_SQUARE;
      S_SQUARE: state_nxt = S_ROOT;
      S_ROOT:   if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {root[2], root[1], root[0]};
      out_last_r <= mask_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks.
  `SOBM_ASSERT_IMP(a_roots_in_step, clk, rst_n, state_r == S_ROOT, $countones(root_done) == 0 || root_done == 3'b111)
  `SOBM_ASSERT_NXT(a_accept_reads, clk, rst_n, accept && !ignore, state_r == S_READ)
  `SOBM_ASSERT_NXT(a_hold_result, clk, rst_n, state_r == S_ROOT && root_done[0] && out_valid_r && !out_tready, state_r == S_ROOT)
endmodule
`default_nettype wire

// ===== dv/sobel_edge_magnitude_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Watches the configuration, input and result channels of the block. It keeps
// its own copy of the line stores, the window and the frame positions, works
// out the result, if any, due for each accepted input item, and compares each
// accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none
module sobel_edge_magnitude_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [23:0]                     in_tdata,  // in_red, in_green, in_blue
  input  wire logic [0:0]                      in_tuser,  // command
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [23:0]                     out_tdata, // out_red, out_green, out_blue
  input  wire logic                            out_tlast,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [sobm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sobm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   result_count,
  output int                                   frame_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sobm_pkg::*;

  localparam int LINE_MAX = 1024;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } gradient_t;

  // Predicted block state; channel index 0 is red, 1 green, 2 blue.
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  logic [7:0]      upper_line [LINE_MAX][3];
  logic [7:0]      middle_line[LINE_MAX][3];
  logic [7:0]      window     [3][3][3];
  int unsigned     in_col, in_row, out_col, out_row;
  gradient_t       expected_q[$];

  // Rounded magnitude of one channel with border masking.
  function automatic logic [7:0] channel_magnitude(int ch, bit top, bit bot, bit lft, bit rgt);
    int v[3][3];
    int gx, gy;
    int unsigned s, n;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && !top) || (r == 2 && !bot) || (c == 0 && !lft) || (c == 2 && !rgt))
          v[r][c] = 0;
        else
          v[r][c] = window[r][c][ch];
      end
    gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
    gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
    s = gx * gx + gy * gy;
    n = 0;
    for (int unsigned k = 1; k <= 255; k++)
      if (k * (k - 1) < s) n = k;
    return n[7:0];
  endfunction

  // Advance the predicted state by one accepted input item.
  function automatic void predict_gradient(logic flush, logic [23:0] data);
    int unsigned w, h, x;
    longint unsigned lin;
    bit pixels_due, top, bot, lft, rgt;
    logic [7:0] px[3];
    gradient_t g;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    pixels_due = in_row < h;
    if (flush && pixels_due) return;
    if (flush && in_row == 0 && in_col == 0) return;
    for (int ch = 0; ch < 3; ch++)
      px[ch] = pixels_due ? data[8*ch +: 8] : 8'd0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    x = in_col;
    lin = longint'(in_row) * w + x;
    for (int r = 0; r < 3; r++)
      for (int ch = 0; ch < 3; ch++) begin
        window[r][0][ch] = window[r][1][ch];
        window[r][1][ch] = window[r][2][ch];
      end
    for (int ch = 0; ch < 3; ch++) begin
      window[0][2][ch]  = upper_line[x][ch];
      window[1][2][ch]  = middle_line[x][ch];
      window[2][2][ch]  = px[ch];
      upper_line[x][ch] = middle_line[x][ch];
      middle_line[x][ch] = px[ch];
    end
    in_col = x + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (lin < w + 1) return;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    top = out_row != 0;
    bot = out_row + 1 < h;
    lft = out_col != 0;
    rgt = out_col + 1 < w;
    g.red   = channel_magnitude(0, top, bot, lft, rgt);
    g.green = channel_magnitude(1, top, bot, lft, rgt);
    g.blue  = channel_magnitude(2, top, bot, lft, rgt);
    g.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_q.push_back(g);
    if (g.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin
    gradient_t e;
    if (!rst_n) begin
      width_reg  = 640;
      height_reg = 480;
      for (int i = 0; i < LINE_MAX; i++)
        for (int ch = 0; ch < 3; ch++) begin
          upper_line[i][ch]  = '0;
          middle_line[i][ch] = '0;
        end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          for (int ch = 0; ch < 3; ch++) window[r][c][ch] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      expected_q.delete();
    end else begin
      // Results first: they can only belong to earlier items.
      if (out_tvalid && out_tready) begin
        result_count++;
        if (out_tlast) frame_count++;
        if (expected_q.size() == 0) begin
          $error("unexpected result item: tdata=%h tlast=%b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[7:0] !== e.red) begin
            $error("out_red: expected %0d, actual %0d", e.red, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[15:8] !== e.green) begin
            $error("out_green: expected %0d, actual %0d", e.green, out_tdata[15:8]);
            fail_count++;
          end
          if (out_tdata[23:16] !== e.blue) begin
            $error("out_blue: expected %0d, actual %0d", e.blue, out_tdata[23:16]);
            fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("frame_last: expected %0b, actual %0b", e.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
        else if (cfg_index == CFG_FRAME_HEIGHT) height_reg = cfg_data[FH_W-1:0];
      end
      if (in_tvalid && in_tready) predict_gradient(in_tuser[0], in_tdata);
    end
    pending_count = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
    frame_count = 0;
  end
endmodule
`default_nettype wire

// ===== dv/sobel_edge_magnitude_tb.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Drives frames of RGB pixels and flush items through the block with random
// gaps and stalls on both sides, changes the frame size between frames, and
// lets the checker judge every result. Directed frames cover the size
// extremes, out-of-range sizes, ignored flushes and late pixels.
// ----------------------------------------------------------------------------
`default_nettype none
module sobel_edge_magnitude_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sobm_pkg::*;

  localparam int CMD_PIXEL = 0;
  localparam int CMD_FLUSH = 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int  fail_count, pending_count, result_count, frame_count;
  int  items_sent = 0;
  bit  calm = 0;       // no idling on either side
  bit  hold_out = 0;   // receiver holds off for a long stretch

  always #5 clk = ~clk;

  sobel_edge_magnitude DUT (.*);

  sobel_edge_magnitude_checker u_checker (.*);

  // Receiver: random stalls, a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_out = 0;
      end
      out_tready = calm ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // Offer one input item and wait for its acceptance.
  task automatic send_item(int cmd, logic [23:0] data);
    while (!calm && $urandom_range(99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = 1'(cmd);
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Frame size write; unused width bits carry random values.
  task automatic set_size(int w, int h);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, {5'($urandom), 11'(w)});
    write_reg(CFG_FRAME_HEIGHT, 16'(h));
  endtask

  function automatic logic [23:0] make_pixel(int style);
    logic [23:0] p;
    p = 24'($urandom);
    if (style == 1)
      for (int ch = 0; ch < 3; ch++) p[8*ch +: 8] = p[ch] ? 8'hFF : 8'h00;
    return p;
  endfunction

  // One frame at size w x h plus the flush items that drain it. Noise items
  // (ignored flushes, late pixels) are mixed in on request, and the receiver
  // can be told to hold off while the frame is offered.
  task automatic run_frame(int w, int h, int style, bit noisy, bit pause_mid,
                           bit stall_out);
    int ew, eh, npix;
    ew = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    eh = (h == 0) ? 1 : h;
    npix = ew * eh;
    set_size(w, h);
    if (stall_out) hold_out = 1;
    if (noisy) send_item(CMD_FLUSH, 24'($urandom));
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(99) < 5) send_item(CMD_FLUSH, 24'($urandom));
      if (pause_mid && i == npix / 2) wait_drained();
      send_item(CMD_PIXEL, make_pixel(style));
    end
    for (int i = 0; i <= ew; i++)
      send_item((noisy && $urandom_range(1)) ? CMD_PIXEL : CMD_FLUSH, 24'($urandom));
    if (noisy) send_item(CMD_FLUSH, 24'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames: extremes, out-of-range sizes and ignored items.
    run_frame(3, 3, 1, 1, 0, 0);
    run_frame(1, 1, 1, 1, 0, 0);
    run_frame(0, 0, 0, 1, 0, 0);
    run_frame(2, 1, 1, 0, 0, 0);
    run_frame(1, 3, 1, 0, 0, 0);
    run_frame(4, 3, 0, 1, 1, 0);

    // Tall frame cut short by a height change, then finished by flushes.
    set_size(1, 65535);
    repeat (6) send_item(CMD_PIXEL, make_pixel(1));
    set_size(1, 2);
    repeat (3) send_item(CMD_FLUSH, 24'($urandom));

    // Random frames; a stretch in the middle runs with no idling.
    while (items_sent < 1250) begin
      calm = (items_sent >= 700 && items_sent < 900) || ($urandom_range(9) == 0);
      w = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      h = $urandom_range(1, 6);
      run_frame(w, h, $urandom_range(1), $urandom_range(9) == 0, $urandom_range(19) == 0, 0);
    end
    calm = 0;

    // Long receiver hold-off while the sender keeps offering a frame.
    run_frame(20, 4, 0, 0, 0, 1);

    // A wider line to exercise more of the row buffers.
    run_frame(120, 1, 1, 0, 0, 0);

    wait_drained();
    repeat (50) @(negedge clk);
    $display("Sent %0d input items; checked %0d results over %0d frames.",
             items_sent, result_count, frame_count);
    $display("Frames from one pixel to 120-pixel lines, with one long receiver stall.");
    if (fail_count == 0)
      $display("sobel_edge_magnitude regression: pass");
    else
      $display("sobel_edge_magnitude regression: fail");
    $finish;
  end

  // Watchdog.
  initial begin
    #9ms;
    $display("sobel_edge_magnitude regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
